/* src/morse_symbol_transmitter_core_assert.svh */
// assertion macros used by the keyer rtl
// needs a clock and an active-low reset in scope where the plain form is used
`ifndef MORSE_SYMBOL_TRANSMITTER_CORE_ASSERT_SVH
`define MORSE_SYMBOL_TRANSMITTER_CORE_ASSERT_SVH

// explicit clock and reset
`define MST_ASSERT_AT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// default clock and reset of the rtl
`define MST_ASSERT(lbl, prop, msg) \
  `MST_ASSERT_AT(lbl, clk_i, rst_ni, prop, msg)

`endif

/* src/mst_pkg.sv */
// shared types, constants and helpers of the morse keyer
// used by every module of the keyer but the queue ram, depends on nothing
package mst_pkg;

  localparam int unsigned QUEUE_DEPTH = 256;
  localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned SUM_W       = PTR_W + 9;
  localparam int unsigned TICK_W      = 16;
  localparam int unsigned CFG_IDX_W   = 3;

  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [TICK_W-1:0] tick_t;

  localparam tick_t DOT_RST     = 16'd80;
  localparam tick_t DASH_RST    = 16'd240;
  localparam tick_t SYMGAP_RST  = 16'd80;
  localparam tick_t LETGAP_RST  = 16'd240;
  localparam tick_t WORDGAP_RST = 16'd560;

  localparam logic [7:0] CHR_DOT   = 8'h2E;
  localparam logic [7:0] CHR_DASH  = 8'h2D;
  localparam logic [7:0] CHR_SPACE = 8'h20;
  localparam logic [7:0] CHR_SLASH = 8'h2F;
  localparam logic [7:0] CHR_LF    = 8'h0A;
  localparam logic [7:0] CHR_CR    = 8'h0D;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DOT     = 3'd0,
    REG_DASH    = 3'd1,
    REG_SYMGAP  = 3'd2,
    REG_LETGAP  = 3'd3,
    REG_WORDGAP = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_DOT     = 3'd1,
    PH_DASH    = 3'd2,
    PH_SYMGAP  = 3'd3,
    PH_LETGAP  = 3'd4,
    PH_WORDGAP = 3'd5
  } phase_e;

  typedef struct packed {
    tick_t dot;
    tick_t dash;
    tick_t symgap;
    tick_t letgap;
    tick_t wordgap;
  } cfg_t;

  typedef struct packed {
    logic [7:0] count;
    logic       dropped;
    phase_e     phase;
    logic       carrier;
  } res_t;

  function automatic ptr_t ptr_inc(ptr_t p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  // bytes held in the ring, saturated to eight bits
  function automatic logic [7:0] pending(ptr_t wr, ptr_t rd);
    logic [SUM_W-1:0] cnt;
    cnt = SUM_W'(wr) - SUM_W'(rd);
    if (wr < rd) cnt = cnt + SUM_W'(QUEUE_DEPTH);
    if (cnt > SUM_W'(255)) return 8'hFF;
    return cnt[7:0];
  endfunction

endpackage

/* src/mst_queue_ram.sv */
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module mst_queue_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 8,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/mst_cfg_regs.sv */
// timing configuration registers of the keyer
// depends on mst_pkg
module mst_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           we_i,
  input  logic [mst_pkg::CFG_IDX_W-1:0]  idx_i,
  input  mst_pkg::tick_t                 data_i,
  output mst_pkg::cfg_t                  cfg_o
);

  mst_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      unique case (idx_i)
        mst_pkg::REG_DOT:     cfg_d.dot     = data_i;
        mst_pkg::REG_DASH:    cfg_d.dash    = data_i;
        mst_pkg::REG_SYMGAP:  cfg_d.symgap  = data_i;
        mst_pkg::REG_LETGAP:  cfg_d.letgap  = data_i;
        mst_pkg::REG_WORDGAP: cfg_d.wordgap = data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dot     <= mst_pkg::DOT_RST;
      cfg_q.dash    <= mst_pkg::DASH_RST;
      cfg_q.symgap  <= mst_pkg::SYMGAP_RST;
      cfg_q.letgap  <= mst_pkg::LETGAP_RST;
      cfg_q.wordgap <= mst_pkg::WORDGAP_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* src/mst_keyer.sv */
// keyer sequencer: ring queue pointers, phase timing and the queue memory
// depends on mst_pkg, mst_queue_ram and the assertion header
`include "morse_symbol_transmitter_core_assert.svh"

module mst_keyer (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mst_pkg::cfg_t   cfg_i,
  input  logic            in_valid_i,
  input  logic            in_action_i,
  input  logic [7:0]      in_byte_i,
  output logic            in_ready_o,
  input  logic            slot_free_i,
  output logic            res_valid_o,
  output mst_pkg::res_t   res_o
);

  typedef enum logic [1:0] {
    ST_READY,
    ST_READ,
    ST_EVAL,
    ST_DONE
  } st_e;

  st_e             state_q, state_d;
  mst_pkg::ptr_t   rd_ptr_q, rd_ptr_d;
  mst_pkg::ptr_t   wr_ptr_q, wr_ptr_d;
  mst_pkg::phase_e phase_q, phase_d;
  mst_pkg::tick_t  elapsed_q, elapsed_d;
  mst_pkg::tick_t  len_q, len_d;
  logic            carrier_q, carrier_d;
  logic            dropped_q, dropped_d;

  logic            ram_we;
  logic            ram_re;
  logic [7:0]      ram_rdata;
  mst_pkg::ptr_t   wr_next;
  mst_pkg::tick_t  el_inc;
  logic            mark;

  mst_queue_ram #(
    .DEPTH (mst_pkg::QUEUE_DEPTH),
    .WIDTH (8)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_ptr_q),
    .wdata_i (in_byte_i),
    .re_i    (ram_re),
    .raddr_i (rd_ptr_q),
    .rdata_o (ram_rdata)
  );

  assign wr_next = mst_pkg::ptr_inc(wr_ptr_q);
  assign el_inc  = (elapsed_q == 16'hFFFF) ? elapsed_q : elapsed_q + 16'd1;
  assign mark    = (phase_q == mst_pkg::PH_DOT) || (phase_q == mst_pkg::PH_DASH);

  always_comb begin
    state_d     = state_q;
    rd_ptr_d    = rd_ptr_q;
    wr_ptr_d    = wr_ptr_q;
    phase_d     = phase_q;
    elapsed_d   = elapsed_q;
    len_d       = len_q;
    carrier_d   = carrier_q;
    dropped_d   = dropped_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    unique case (state_q)
      ST_READY: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          dropped_d = 1'b0;
          state_d   = ST_DONE;
          if (in_action_i) begin
            if (wr_next == rd_ptr_q) begin
              // full ring: drop and flush
              rd_ptr_d  = '0;
              wr_ptr_d  = '0;
              dropped_d = 1'b1;
            end else begin
              ram_we   = 1'b1;
              wr_ptr_d = wr_next;
              if ((in_byte_i == mst_pkg::CHR_LF || in_byte_i == mst_pkg::CHR_CR) &&
                  phase_q == mst_pkg::PH_IDLE) begin
                state_d = ST_READ;
              end
            end
          end else if (phase_q != mst_pkg::PH_IDLE) begin
            elapsed_d = el_inc;
            carrier_d = mark & el_inc[0];
            if (el_inc >= len_q) begin
              carrier_d = 1'b0;
              if (mark) begin
                phase_d   = mst_pkg::PH_SYMGAP;
                len_d     = cfg_i.symgap;
                elapsed_d = '0;
              end else begin
                state_d = ST_READ;
              end
            end
          end
        end
      end
      ST_READ: begin
        if (rd_ptr_q == wr_ptr_q) begin
          phase_d = mst_pkg::PH_IDLE;
          state_d = ST_DONE;
        end else begin
          ram_re  = 1'b1;
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        rd_ptr_d  = mst_pkg::ptr_inc(rd_ptr_q);
        elapsed_d = '0;
        state_d   = ST_DONE;
        case (ram_rdata)
          mst_pkg::CHR_DOT: begin
            phase_d = mst_pkg::PH_DOT;
            len_d   = cfg_i.dot;
          end
          mst_pkg::CHR_DASH: begin
            phase_d = mst_pkg::PH_DASH;
            len_d   = cfg_i.dash;
          end
          mst_pkg::CHR_SPACE: begin
            phase_d = mst_pkg::PH_LETGAP;
            len_d   = cfg_i.letgap;
          end
          mst_pkg::CHR_SLASH: begin
            phase_d = mst_pkg::PH_WORDGAP;
            len_d   = cfg_i.wordgap;
          end
          default: state_d = ST_READ;
        endcase
      end
      ST_DONE: begin
        if (slot_free_i) begin
          res_valid_o = 1'b1;
          state_d     = ST_READY;
        end
      end
      default: state_d = ST_READY;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_READY;
      rd_ptr_q  <= '0;
      wr_ptr_q  <= '0;
      phase_q   <= mst_pkg::PH_IDLE;
      elapsed_q <= '0;
      len_q     <= '0;
      carrier_q <= 1'b0;
      dropped_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_ptr_q  <= rd_ptr_d;
      wr_ptr_q  <= wr_ptr_d;
      phase_q   <= phase_d;
      elapsed_q <= elapsed_d;
      len_q     <= len_d;
      carrier_q <= carrier_d;
      dropped_q <= dropped_d;
    end
  end

  assign res_o.count   = mst_pkg::pending(wr_ptr_q, rd_ptr_q);
  assign res_o.dropped = dropped_q;
  assign res_o.phase   = phase_q;
  assign res_o.carrier = carrier_q;

  `MST_ASSERT(a_carrier_in_mark, carrier_q |-> mark, "carrier on outside a mark")
  `MST_ASSERT(a_read_not_empty, ram_re |-> (rd_ptr_q != wr_ptr_q), "queue read while empty")
  `MST_ASSERT(a_eval_read, state_q == ST_EVAL |-> $past(state_q) == ST_READ, "eval without read")

endmodule

/* src/morse_symbol_transmitter_core.sv */
// top level of the morse keyer: stream ports, config registers, result register
// depends on mst_pkg, mst_cfg_regs and mst_keyer
//
//   channel   | ports              | contents
//   ----------+--------------------+--------------------------------------------
//   input     | s_axis_*           | request: tick or received byte
//   result    | m_axis_*           | carrier, phase, flush flag, pending count
//   config    | cfg_we_i/idx/data  | timing register writes, no read-back
//
// a tick or a byte that starts no fetch is accepted, then its result is loaded
// a fetch pops bytes one by one (queue ram read, then decode) until a keyable one
// turns up, or the queue runs dry and the phase falls back to idle
// the next request is taken while a result still waits in the output register
// reset clears pointers, phase and timers and loads the default timing
module morse_symbol_transmitter_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,  // rx_byte
  input  logic [0:0]                     s_axis_tuser,  // action
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // carrier_on, current_phase[2:0], dropped_flush, pending_count[7:0], zero fill
  output logic [15:0]                    m_axis_tdata,
  input  logic                           cfg_we_i,
  input  logic [mst_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [15:0]                    cfg_data_i
);

  mst_pkg::cfg_t cfg;
  mst_pkg::res_t res;
  mst_pkg::res_t out_q;
  logic          res_valid;
  logic          out_valid_q;
  logic          slot_free;

  mst_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .idx_i  (cfg_idx_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  mst_keyer u_keyer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (s_axis_tvalid),
    .in_action_i (s_axis_tuser[0]),
    .in_byte_i   (s_axis_tdata),
    .in_ready_o  (s_axis_tready),
    .slot_free_i (slot_free),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign slot_free = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_q.count, out_q.dropped, out_q.phase, out_q.carrier};

endmodule

/* tb/sv/keyer_stream_checker.sv */
// keyer_stream_checker: watches the request, result and config ports of the keyer
// keeps its own ring queue, sequencer and timing copy, predicts every result and compares
// depends on mst_pkg
module keyer_stream_checker
  import mst_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,  // rx_byte
  input  logic [0:0]           s_axis_tuser,  // action
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // carrier_on, current_phase[2:0], dropped_flush, pending_count[7:0], zero fill
  input  logic [15:0]          m_axis_tdata,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [15:0]          cfg_data_i,
  output int unsigned          mismatches_o,
  output int unsigned          outstanding_o
);

  localparam int unsigned RES_W = $bits(res_t);

  logic [7:0]  ring [QUEUE_DEPTH];
  ptr_t        rd_ptr;
  ptr_t        wr_ptr;
  phase_e      seq_phase;
  tick_t       elapsed;
  tick_t       phase_len;
  logic        carrier;
  cfg_t        timing;
  res_t        expected_results [$];
  res_t        got;
  res_t        want;
  logic        flushed;
  int unsigned mismatch_cnt;

  function automatic ptr_t ring_next(ptr_t p);
    return ptr_t'((int'(p) + 1) % QUEUE_DEPTH);
  endfunction

  function automatic logic [7:0] queued_bytes();
    int unsigned n;
    n = (int'(wr_ptr) + QUEUE_DEPTH - int'(rd_ptr)) % QUEUE_DEPTH;
    return (n > 255) ? 8'hFF : 8'(n);
  endfunction

  function automatic void enter_phase(phase_e p, tick_t len);
    seq_phase = p;
    phase_len = len;
    elapsed   = '0;
  endfunction

  // pop until a keyable character turns up, otherwise fall back to idle
  function automatic void pop_symbol();
    logic [7:0] c;
    for (int n = 0; n < QUEUE_DEPTH && rd_ptr != wr_ptr; n++) begin
      c       = ring[rd_ptr];
      rd_ptr  = ring_next(rd_ptr);
      elapsed = '0;
      case (c)
        CHR_DOT: begin
          enter_phase(PH_DOT, timing.dot);
          return;
        end
        CHR_DASH: begin
          enter_phase(PH_DASH, timing.dash);
          return;
        end
        CHR_SPACE: begin
          enter_phase(PH_LETGAP, timing.letgap);
          return;
        end
        CHR_SLASH: begin
          enter_phase(PH_WORDGAP, timing.wordgap);
          return;
        end
        default: ;
      endcase
    end
    seq_phase = PH_IDLE;
  endfunction

  function automatic void advance_tick();
    logic mark;
    if (seq_phase == PH_IDLE) return;
    if (elapsed != 16'hFFFF) elapsed = elapsed + 16'd1;
    mark    = (seq_phase == PH_DOT) || (seq_phase == PH_DASH);
    carrier = mark & elapsed[0];
    if (elapsed >= phase_len) begin
      carrier = 1'b0;
      if (mark) enter_phase(PH_SYMGAP, timing.symgap);
      else pop_symbol();
    end
  endfunction

  function automatic logic enqueue_byte(logic [7:0] b);
    ptr_t nxt;
    nxt = ring_next(wr_ptr);
    if (nxt == rd_ptr) begin
      rd_ptr = '0;
      wr_ptr = '0;
      return 1'b1;
    end
    ring[wr_ptr] = b;
    wr_ptr       = nxt;
    if ((b == CHR_LF || b == CHR_CR) && seq_phase == PH_IDLE) pop_symbol();
    return 1'b0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (ring[i]) ring[i] = '0;
      rd_ptr         = '0;
      wr_ptr         = '0;
      seq_phase      = PH_IDLE;
      elapsed        = '0;
      phase_len      = '0;
      carrier        = 1'b0;
      timing         = '{DOT_RST, DASH_RST, SYMGAP_RST, LETGAP_RST, WORDGAP_RST};
      mismatch_cnt   = 0;
      expected_results.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_DOT:     timing.dot     = cfg_data_i;
          REG_DASH:    timing.dash    = cfg_data_i;
          REG_SYMGAP:  timing.symgap  = cfg_data_i;
          REG_LETGAP:  timing.letgap  = cfg_data_i;
          REG_WORDGAP: timing.wordgap = cfg_data_i;
          default: ;
        endcase
      end
      // results first, so a result never meets the expectation of this very edge
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          $error("result with nothing expected, tdata %h", m_axis_tdata);
          mismatch_cnt++;
        end else begin
          want = expected_results.pop_front();
          got  = res_t'(m_axis_tdata[RES_W-1:0]);
          if (got.carrier !== want.carrier) begin
            $error("carrier_on: expected %0d, got %0d", want.carrier, got.carrier);
            mismatch_cnt++;
          end
          if (got.phase !== want.phase) begin
            $error("current_phase: expected %0d, got %0d", want.phase, got.phase);
            mismatch_cnt++;
          end
          if (got.dropped !== want.dropped) begin
            $error("dropped_flush: expected %0d, got %0d", want.dropped, got.dropped);
            mismatch_cnt++;
          end
          if (got.count !== want.count) begin
            $error("pending_count: expected %0d, got %0d", want.count, got.count);
            mismatch_cnt++;
          end
          if (m_axis_tdata[15:RES_W] !== '0) begin
            $error("zero fill: expected 0, got %0h", m_axis_tdata[15:RES_W]);
            mismatch_cnt++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        flushed = 1'b0;
        if (s_axis_tuser[0]) flushed = enqueue_byte(s_axis_tdata);
        else advance_tick();
        want.carrier = carrier;
        want.phase   = seq_phase;
        want.dropped = flushed;
        want.count   = queued_bytes();
        expected_results.push_back(want);
      end
    end
    mismatches_o  <= mismatch_cnt;
    outstanding_o <= expected_results.size();
  end

endmodule

/* tb/sv/tb_top.sv */
// tb_top: clock, reset, tick and byte requests, timing register writes and the verdict
// needs mst_pkg, morse_symbol_transmitter_core and keyer_stream_checker
module tb_top;
  import mst_pkg::*;

  localparam int unsigned IDLE_LIMIT    = 20000;
  localparam int unsigned SETTLE_CYCLES = 64;
  localparam int unsigned REG_LAST      = REG_WORDGAP;
  localparam logic        ACT_TICK      = 1'b0;
  localparam logic        ACT_BYTE      = 1'b1;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_RHYTHM} rx_mode_e;

  logic                 clk_i;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata  = '0;
  logic [0:0]           s_axis_tuser  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [15:0]          m_axis_tdata;
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i     = '0;
  logic [15:0]          cfg_data_i    = '0;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned burst_left   = 0;
  int unsigned sent         = 0;
  int unsigned idle_cycles  = 0;
  rx_mode_e    rx_mode      = RX_OPEN;
  int unsigned rx_mode_left = 0;
  int unsigned rx_beat      = 0;

  morse_symbol_transmitter_core dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  keyer_stream_checker u_stream_check (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // result side stalls on its own changing pattern
  always @(posedge clk_i) begin
    if (rx_mode_left == 0) begin
      rx_mode      <= rx_mode_e'($urandom_range(0, 3));
      rx_mode_left <= $urandom_range(50, 300);
    end else begin
      rx_mode_left <= rx_mode_left - 1;
    end
    rx_beat <= rx_beat + 1;
    case (rx_mode)
      RX_OPEN:   m_axis_tready <= 1'b1;
      RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
      RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
      default:   m_axis_tready <= ((rx_beat % 7) < 3);
    endcase
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (rst_ni) begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send(input logic act, input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      gap = $urandom_range(0, 5);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    burst_left--;
    sent++;
  endtask

  task automatic send_tick();
    send(ACT_TICK, 8'($urandom));
  endtask

  // hold off until every predicted result has been taken
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    burst_left = 0;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input tick_t v);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
  endtask

  task automatic write_timing(input cfg_t t);
    write_reg(REG_DOT, t.dot);
    write_reg(REG_DASH, t.dash);
    write_reg(REG_SYMGAP, t.symgap);
    write_reg(REG_LETGAP, t.letgap);
    write_reg(REG_WORDGAP, t.wordgap);
    // an index past the register list must change nothing
    write_reg(CFG_IDX_W'($urandom_range(REG_LAST + 1, (1 << CFG_IDX_W) - 1)), 16'($urandom));
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic cfg_t flat_timing(tick_t v);
    return '{v, v, v, v, v};
  endfunction

  function automatic cfg_t random_timing(int unsigned lo, int unsigned hi);
    return '{tick_t'($urandom_range(lo, hi)), tick_t'($urandom_range(lo, hi)),
             tick_t'($urandom_range(lo, hi)), tick_t'($urandom_range(lo, hi)),
             tick_t'($urandom_range(lo, hi))};
  endfunction

  // rough number of ticks one queued character keeps the keyer busy
  function automatic int unsigned char_span(cfg_t t);
    int unsigned m;
    m = t.dot;
    if (t.dash > m) m = t.dash;
    if (t.letgap > m) m = t.letgap;
    if (t.wordgap > m) m = t.wordgap;
    return m + t.symgap + 1;
  endfunction

  // a few morse characters, mostly with a line end, then ticks to key them out
  task automatic play_message(input int unsigned span);
    int unsigned n;
    logic [7:0]  b;
    n = $urandom_range(1, 8);
    repeat (n) begin
      case ($urandom_range(0, 9))
        0:       b = 8'($urandom);
        1, 2, 3: b = CHR_DOT;
        4, 5, 6: b = CHR_DASH;
        7:       b = CHR_SPACE;
        default: b = CHR_SLASH;
      endcase
      send(ACT_BYTE, b);
      if ($urandom_range(0, 4) == 0) send_tick();
    end
    if ($urandom_range(0, 7) != 0) send(ACT_BYTE, $urandom_range(0, 1) ? CHR_LF : CHR_CR);
    repeat ($urandom_range(0, n * span + 2)) send_tick();
  endtask

  task automatic run_phase(input cfg_t t, input int unsigned budget);
    int unsigned first;
    drain();
    write_timing(t);
    first = sent;
    while (sent - first < budget) play_message(char_span(t));
  endtask

  initial begin
    cfg_t t;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset timing: idle tick, skipped bytes, line end starts a long dot
    send_tick();
    send(ACT_BYTE, CHR_DOT);
    send(ACT_BYTE, 8'hFF);
    send(ACT_BYTE, 8'h00);
    send(ACT_BYTE, CHR_LF);
    repeat (3) send_tick();
    drain();

    t = '{dot: 16'd1, dash: 16'd2, symgap: 16'd0, letgap: 16'd1, wordgap: 16'd3};
    write_timing(t);
    send(ACT_BYTE, CHR_DASH);
    send(ACT_BYTE, CHR_SPACE);
    send(ACT_BYTE, CHR_SLASH);
    send(ACT_BYTE, 8'h61);
    send(ACT_BYTE, CHR_CR);
    repeat (12) send_tick();

    run_phase(flat_timing(16'd1), 250);
    run_phase(flat_timing(16'd0), 250);
    run_phase(random_timing(0, 3), 400);
    run_phase(random_timing(0, 8), 450);

    // longest timing keeps the keyer busy so the ring fills up and flushes
    drain();
    write_timing(flat_timing(16'hFFFF));
    send(ACT_BYTE, CHR_LF);
    send(ACT_BYTE, CHR_DASH);
    send(ACT_BYTE, CHR_LF);
    repeat (20) send_tick();
    repeat (400) begin
      if ($urandom_range(0, 15) == 0) send_tick();
      else send(ACT_BYTE, 8'($urandom));
    end

    drain();
    if (mismatches == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
